// File: sv/velsl_pkg.sv
// Package for the velocity slew limiter: state codes, register indexes and widths.
// No dependencies; the core module imports it.
`default_nettype none

package velsl_pkg;

   // Register indexes on the csr port
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_CMD_VEL_LIMIT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CMD_ANG_LIMIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_STEP          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANG_STEP          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HW_VEL_LIMIT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HW_ANG_LIMIT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HW_DECEL_STEPS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRIPETAL_LIMIT = 3'd7;

   localparam int unsigned CSR_DATA_W = 63;
   localparam int unsigned LIM_W      = 31;   // unsigned limits and steps
   localparam int unsigned VAL_W      = 32;   // signed Q16.16 velocities
   localparam int unsigned FLAG_W     = 5;

   // Flag bit positions
   localparam int unsigned FLG_VEL_LIM = 0;
   localparam int unsigned FLG_VEL_STP = 1;
   localparam int unsigned FLG_ANG_LIM = 2;
   localparam int unsigned FLG_ANG_STP = 3;
   localparam int unsigned FLG_CENTRI  = 4;

   // Shared clamp unit width: holds the 48-bit quotient with a sign
   localparam int unsigned CLAMP_W = 49;
   localparam int unsigned SEXT_W  = CLAMP_W - VAL_W;
   localparam int unsigned ZLIM_W  = CLAMP_W - LIM_W;

   // Radix-4 restoring divider: (limit << 16) / |ang|
   localparam int unsigned FRAC_W       = 16;
   localparam int unsigned DVD_W        = 48;
   localparam int unsigned DIV_BITS     = 2;
   localparam int unsigned DIV_ITERS    = DVD_W / DIV_BITS;
   localparam int unsigned DIV_CNT_W    = $clog2(DIV_ITERS);
   localparam int unsigned DVD_PAD_W    = DVD_W - LIM_W - FRAC_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD_V,
      ST_CMD_W,
      ST_STP_V,
      ST_STP_W,
      ST_DIV,
      ST_BND,
      ST_FIN
   } velsl_state_type;

endpackage

`default_nettype wire

// File: sv/velocity_slew_limiter_core.sv
// Velocity slew limiter core: sequencer, shared clamp unit and radix-4 divider.
// Depends on velsl_pkg.
`default_nettype none

// Each accepted req word is one control tick carrying a target linear and angular
// velocity (signed Q16.16). The target is clamped to the commanded limit, then the
// change from the stored smoothed value is clamped to a per-tick step (the hardware
// deceleration step applies while the stored speed is above the hardware limit).
// The linear value is then bounded by centripetal_limit / |previous angular speed|
// when that speed is nonzero. One rsp word carries both new velocities and five
// clamp flags. One shared 49-bit clamp unit performs the command and step clamps
// in turn; the centrifugal bound then runs a 2-bit-per-cycle divider and one more
// clamp. The divider and that clamp are skipped when the previous angular speed
// is zero. A finished item waits in the commit state while the rsp register still
// holds a word that has not been taken. req_ready is high only while the
// sequencer is idle, so a new req word is taken only after the last is committed.
// csr writes are always accepted and must only be issued while the block is idle.
module velocity_slew_limiter_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [velsl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [velsl_pkg::CSR_DATA_W-1:0]  csr_data,
   // request
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [velsl_pkg::VAL_W-1:0] req_target_vel,
   input  wire logic signed [velsl_pkg::VAL_W-1:0] req_target_ang,
   // response
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [velsl_pkg::VAL_W-1:0]     rsp_out_vel,
   output logic signed [velsl_pkg::VAL_W-1:0]     rsp_out_ang,
   output logic [velsl_pkg::FLAG_W-1:0]           rsp_limit_flags
);
   import velsl_pkg::*;

   // ---------------------------------------------------------------- registers
   velsl_state_type state_ff, state_in;

   logic [LIM_W-1:0]      cmd_vel_limit_ff, cmd_ang_limit_ff;
   logic [LIM_W-1:0]      vel_step_ff, ang_step_ff;
   logic [LIM_W-1:0]      hw_vel_limit_ff, hw_ang_limit_ff;
   logic [CSR_DATA_W-1:0] hw_decel_steps_ff;
   logic [LIM_W-1:0]      centripetal_limit_ff;

   logic signed [VAL_W-1:0] vel_smooth_ff, vel_smooth_in;
   logic signed [VAL_W-1:0] ang_smooth_ff, ang_smooth_in;

   // working copies of the tick being processed
   logic signed [VAL_W-1:0] v_ff, v_in;
   logic signed [VAL_W-1:0] w_ff, w_in;
   logic [FLAG_W-1:0]       flags_ff, flags_in;

   // divider
   logic [DVD_W-1:0]     dvd_ff, dvd_in;     // dividend shifts out, quotient shifts in
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_vel_ff, rsp_vel_in;
   logic signed [VAL_W-1:0] rsp_ang_ff, rsp_ang_in;
   logic [FLAG_W-1:0]       rsp_flags_ff, rsp_flags_in;

   // ---------------------------------------------------------------- control
   logic req_take;     // req word accepted
   logic commit;       // results move to the rsp register and the smoothed state
   logic ang_nonzero;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_take    = req_valid && req_ready;
   assign commit      = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign ang_nonzero = (ang_smooth_ff != '0);
   assign csr_ready   = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CMD_V;
         ST_CMD_V: state_in = ST_CMD_W;
         ST_CMD_W: state_in = ST_STP_V;
         ST_STP_V: state_in = ST_STP_W;
         ST_STP_W: state_in = ang_nonzero ? ST_DIV : ST_FIN;
         ST_DIV:   if (cnt_ff == '0) state_in = ST_BND;
         ST_BND:   state_in = ST_FIN;
         ST_FIN:   if (commit) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- step select
   // |smoothed| as unsigned; the most negative value maps to 2^31
   logic [VAL_W-1:0] vel_mag, ang_mag;
   logic [VAL_W-1:0] dv_sel, dw_sel;

   assign vel_mag = vel_smooth_ff[VAL_W-1] ? (~vel_smooth_ff + 1'b1) : vel_smooth_ff;
   assign ang_mag = ang_smooth_ff[VAL_W-1] ? (~ang_smooth_ff + 1'b1) : ang_smooth_ff;

   // hardware deceleration step replaces the normal one above the hardware limit
   assign dv_sel = (vel_mag > {1'b0, hw_vel_limit_ff}) ? hw_decel_steps_ff[VAL_W-1:0]
                                                       : {1'b0, vel_step_ff};
   assign dw_sel = (ang_mag > {1'b0, hw_ang_limit_ff})
                   ? {1'b0, hw_decel_steps_ff[CSR_DATA_W-1:VAL_W]}
                   : {1'b0, ang_step_ff};

   // ---------------------------------------------------------------- clamp unit
   // One shared unit: upper bound checked first, then lower.
   logic signed [CLAMP_W-1:0] cl_val, cl_lo, cl_hi, cl_res;
   logic                      cl_hit;
   logic signed [CLAMP_W-1:0] v_ext, w_ext, vs_ext, ws_ext, dv_ext, dw_ext, quo_ext;

   assign v_ext   = {{SEXT_W{v_ff[VAL_W-1]}}, v_ff};
   assign w_ext   = {{SEXT_W{w_ff[VAL_W-1]}}, w_ff};
   assign vs_ext  = {{SEXT_W{vel_smooth_ff[VAL_W-1]}}, vel_smooth_ff};
   assign ws_ext  = {{SEXT_W{ang_smooth_ff[VAL_W-1]}}, ang_smooth_ff};
   assign dv_ext  = {{SEXT_W{1'b0}}, dv_sel};
   assign dw_ext  = {{SEXT_W{1'b0}}, dw_sel};
   assign quo_ext = {1'b0, dvd_ff};

   always_comb begin
      cl_val = v_ext;
      cl_lo  = '0;
      cl_hi  = '0;
      unique case (state_ff)
         ST_CMD_V: begin
            cl_val = v_ext;
            cl_hi  = {{ZLIM_W{1'b0}}, cmd_vel_limit_ff};
            cl_lo  = -cl_hi;
         end
         ST_CMD_W: begin
            cl_val = w_ext;
            cl_hi  = {{ZLIM_W{1'b0}}, cmd_ang_limit_ff};
            cl_lo  = -cl_hi;
         end
         ST_STP_V: begin
            cl_val = v_ext;
            cl_hi  = vs_ext + dv_ext;
            cl_lo  = vs_ext - dv_ext;
         end
         ST_STP_W: begin
            cl_val = w_ext;
            cl_hi  = ws_ext + dw_ext;
            cl_lo  = ws_ext - dw_ext;
         end
         ST_BND: begin
            cl_val = v_ext;
            cl_hi  = quo_ext;
            cl_lo  = -quo_ext;
         end
         default: begin
            cl_val = v_ext;
            cl_hi  = v_ext;
            cl_lo  = v_ext;
         end
      endcase
   end

   always_comb begin
      priority if (cl_val > cl_hi) begin
         cl_res = cl_hi;
         cl_hit = 1'b1;
      end else if (cl_val < cl_lo) begin
         cl_res = cl_lo;
         cl_hit = 1'b1;
      end else begin
         cl_res = cl_val;
         cl_hit = 1'b0;
      end
   end

   // ---------------------------------------------------------------- divider step
   // Two restoring steps per cycle; remainder always stays below the divisor.
   logic [VAL_W-1:0] div_rem;
   logic [DVD_W-1:0] div_dvd;

   always_comb begin
      logic [VAL_W:0]   part;
      logic [VAL_W+1:0] diff;
      div_rem = rem_ff;
      div_dvd = dvd_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         part = {div_rem, div_dvd[DVD_W-1]};
         diff = {1'b0, part} - {2'b00, ang_mag};
         if (!diff[VAL_W+1]) begin
            div_rem = diff[VAL_W-1:0];
            div_dvd = {div_dvd[DVD_W-2:0], 1'b1};
         end else begin
            div_rem = part[VAL_W-1:0];
            div_dvd = {div_dvd[DVD_W-2:0], 1'b0};
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      v_in          = v_ff;
      w_in          = w_ff;
      flags_in      = flags_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      vel_smooth_in = vel_smooth_ff;
      ang_smooth_in = ang_smooth_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_ang_in    = rsp_ang_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               v_in     = req_target_vel;
               w_in     = req_target_ang;
               flags_in = '0;
            end
         end
         ST_CMD_V: begin
            v_in                  = cl_res[VAL_W-1:0];
            flags_in[FLG_VEL_LIM] = cl_hit;
         end
         ST_CMD_W: begin
            w_in                  = cl_res[VAL_W-1:0];
            flags_in[FLG_ANG_LIM] = cl_hit;
         end
         ST_STP_V: begin
            v_in                  = cl_res[VAL_W-1:0];
            flags_in[FLG_VEL_STP] = cl_hit;
         end
         ST_STP_W: begin
            w_in                  = cl_res[VAL_W-1:0];
            flags_in[FLG_ANG_STP] = cl_hit;
            // load divider: centripetal_limit << 16
            dvd_in = {{DVD_PAD_W{1'b0}}, centripetal_limit_ff, {FRAC_W{1'b0}}};
            rem_in = '0;
            cnt_in = DIV_CNT_W'(DIV_ITERS - 1);
         end
         ST_DIV: begin
            dvd_in = div_dvd;
            rem_in = div_rem;
            cnt_in = cnt_ff - 1'b1;
         end
         ST_BND: begin
            v_in                 = cl_res[VAL_W-1:0];
            flags_in[FLG_CENTRI] = cl_hit;
         end
         ST_FIN: begin
            if (commit) begin
               vel_smooth_in = v_ff;
               ang_smooth_in = w_ff;
               rsp_vel_in    = v_ff;
               rsp_ang_in    = w_ff;
               rsp_flags_in  = flags_ff;
               rsp_valid_in  = 1'b1;
            end
         end
         default: begin
            v_in = v_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------- csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vel_limit_ff     <= '0;
         cmd_ang_limit_ff     <= '0;
         vel_step_ff          <= '0;
         ang_step_ff          <= '0;
         hw_vel_limit_ff      <= '1;
         hw_ang_limit_ff      <= '1;
         hw_decel_steps_ff    <= '0;
         centripetal_limit_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CMD_VEL_LIMIT:     cmd_vel_limit_ff     <= csr_data[LIM_W-1:0];
            REG_CMD_ANG_LIMIT:     cmd_ang_limit_ff     <= csr_data[LIM_W-1:0];
            REG_VEL_STEP:          vel_step_ff          <= csr_data[LIM_W-1:0];
            REG_ANG_STEP:          ang_step_ff          <= csr_data[LIM_W-1:0];
            REG_HW_VEL_LIMIT:      hw_vel_limit_ff      <= csr_data[LIM_W-1:0];
            REG_HW_ANG_LIMIT:      hw_ang_limit_ff      <= csr_data[LIM_W-1:0];
            REG_HW_DECEL_STEPS:    hw_decel_steps_ff    <= csr_data;
            REG_CENTRIPETAL_LIMIT: centripetal_limit_ff <= csr_data[LIM_W-1:0];
            default:               cmd_vel_limit_ff     <= cmd_vel_limit_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- state regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vel_smooth_ff <= '0;
         ang_smooth_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vel_smooth_ff <= vel_smooth_in;
         ang_smooth_ff <= ang_smooth_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      w_ff         <= w_in;
      flags_ff     <= flags_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_ang_ff   <= rsp_ang_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_vel     = rsp_vel_ff;
   assign rsp_out_ang     = rsp_ang_ff;
   assign rsp_limit_flags = rsp_flags_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTH
   // a fresh response only comes out of the commit state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("rsp word raised outside commit");

   // centrifugal flag needs a nonzero previous angular speed
   a_centri_needs_ang: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BND) |-> ang_nonzero)
      else $error("centrifugal bound with zero angular speed");

   // a pending response always matches the stored smoothed pair
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_vel_ff == vel_smooth_ff) && (rsp_ang_ff == ang_smooth_ff))
      else $error("rsp word differs from smoothed state");
`endif

endmodule

`default_nettype wire
